// File: rtl/core/xswe_pkg.sv
// Shared types and constants for the x86 stack word engine.
`default_nettype none
package xswe_pkg;
  localparam int STACK_WORDS_LOG2 = 10;
  localparam int STACK_WORDS = 1 << STACK_WORDS_LOG2;
  localparam int CLR_W = STACK_WORDS_LOG2 + 1;

  typedef logic [STACK_WORDS_LOG2-1:0] word_idx_t;

  typedef enum logic [2:0] {
    FN_PUSH_VAL = 3'd0,
    FN_PUSH_REG = 3'd1,
    FN_POP_REG  = 3'd2,
    FN_POP_OUT  = 3'd3,
    FN_PUSHA    = 3'd4,
    FN_POPA     = 3'd5,
    FN_ENTER    = 3'd6,
    FN_LEAVE    = 3'd7
  } func_t;

  localparam logic [2:0] R_SP = 3'd4;
  localparam logic [2:0] R_BP = 3'd5;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,      // write zero at clear index
    OP_LATCH,      // capture instruction fields, snapshot SP/BP
    OP_PUSH,       // sp -= 2, write source word, emit
    OP_POP_READ,   // issue read at sp (or bp for leave)
    OP_POP_DONE,   // emit read data, update registers
    OP_DISP_READ,  // bp_tmp -= 2, read display word
    OP_FRAME,      // sp -= frame_bytes
    OP_PROBE_READ, // issue read at sp
    OP_PROBE_DONE  // emit probe read, BP <- frame
  } op_t;

  typedef enum logic [2:0] {
    SRC_VALUE, SRC_REG, SRC_BP, SRC_DISP, SRC_FRAME, SRC_PUSHA
  } src_t;

  typedef struct packed {
    op_t        op;
    src_t       src;
    logic [2:0] k;       // register / step number
    logic       last;
    logic [CLR_W-1:0] clr_idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/core/x86_stack_word_engine.sv
// Top level of the x86 16-bit stack instruction engine.
//
// One instruction is taken per transfer on the input channel (func, reg_index,
// push_value, frame_bytes, nest_level). Each stack access it makes comes out
// as one transfer on the output channel, and the final one carries last.
// A push takes the input transfer and then one write; a single pop or LEAVE
// steps through address, registered store read and result. PUSHA makes one
// write per cycle while the receiver takes each access; POPA alternates a
// read state and a result state for each word. ENTER pushes BP; at a nonzero
// level it copies the display and pushes the new frame pointer; it then lowers
// SP by frame_bytes and reads at the new SP. The store has one read port.
// The configuration channel writes stack_big, which selects 32-bit ESP/EBP
// arithmetic; write it only while no instruction is in flight.
// After reset the engine sweeps the stack store to zero, one word per cycle
// (STACK_WORDS words, 1024 by default), and takes no instruction meanwhile.
// Registers reset to zero. When the receiver stalls, the finished access
// waits in the output register and the sequencer holds until it is taken.
`default_nettype none
module x86_stack_word_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        stack_big,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [2:0]  reg_index,
  input  wire logic [15:0] push_value,
  input  wire logic [15:0] frame_bytes,
  input  wire logic [7:0]  nest_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      mem_address,
  output logic [15:0]      mem_data,
  output logic             mem_write,
  output logic             last
);
  logic big;
  xswe_pkg::cmd_t  cmd;
  xswe_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) big <= 1'b0;
    else if (cfg_valid) big <= stack_big;
  end

  xswe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .func, .nest_level, .stat, .cmd
  );

  xswe_dp u_dp (
    .clk, .rst, .stack_big(big), .cmd, .stat, .func, .reg_index, .push_value,
    .frame_bytes, .out_valid, .out_ready, .mem_address, .mem_data, .mem_write, .last
  );

  // A stalled result must hold.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mem_address) && $stable(mem_data))
    else $error("stalled result changed");
  // Once an instruction is taken the engine is busy in the cycle that follows.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("instruction accepted on consecutive cycles");
endmodule
`default_nettype wire

// File: rtl/core/xswe_ctrl.sv
// Controller state machine sequencing stack accesses for each instruction.
`default_nettype none
module xswe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      func,
  input  wire logic [7:0]      nest_level,
  input  wire xswe_pkg::stat_t stat,
  output xswe_pkg::cmd_t       cmd
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PUSH, S_POPR, S_POPD, S_PUSHA, S_POPAR, S_POPAD,
    S_EBP, S_DISP_R, S_DISP_W, S_EFRAME, S_ESUB, S_PROBER, S_PROBED
  } state_t;

  state_t state;
  logic [2:0] fn;
  logic [2:0] k;
  logic [4:0] cnt;
  logic [4:0] lvl;
  logic [xswe_pkg::CLR_W-1:0] clr;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.op = xswe_pkg::OP_NONE;
    cmd.src = xswe_pkg::SRC_VALUE;
    cmd.clr_idx = clr;
    cmd.k = k;
    unique case (state)
      S_CLEAR: cmd.op = xswe_pkg::OP_CLEAR;
      S_IDLE: if (in_valid) cmd.op = xswe_pkg::OP_LATCH;
      S_PUSH: if (!stat.out_busy) begin
        cmd.op = xswe_pkg::OP_PUSH;
        cmd.src = (fn == xswe_pkg::FN_PUSH_VAL) ? xswe_pkg::SRC_VALUE : xswe_pkg::SRC_REG;
        cmd.last = 1'b1;
      end
      S_POPR, S_POPAR: cmd.op = xswe_pkg::OP_POP_READ;
      S_POPD, S_POPAD: if (!stat.out_busy) begin
        cmd.op = xswe_pkg::OP_POP_DONE;
        cmd.last = (state == S_POPD) || (k == 3'd7);
      end
      S_PUSHA: if (!stat.out_busy) begin
        cmd.op = xswe_pkg::OP_PUSH;
        cmd.src = xswe_pkg::SRC_PUSHA;
        cmd.last = (k == 3'd7);
      end
      S_EBP: if (!stat.out_busy) begin
        cmd.op = xswe_pkg::OP_PUSH;
        cmd.src = xswe_pkg::SRC_BP;
      end
      S_DISP_R: cmd.op = xswe_pkg::OP_DISP_READ;
      S_DISP_W: if (!stat.out_busy) begin
        cmd.op = xswe_pkg::OP_PUSH;
        cmd.src = xswe_pkg::SRC_DISP;
      end
      S_EFRAME: if (!stat.out_busy) begin
        cmd.op = xswe_pkg::OP_PUSH;
        cmd.src = xswe_pkg::SRC_FRAME;
      end
      S_ESUB: cmd.op = xswe_pkg::OP_FRAME;
      S_PROBER: cmd.op = xswe_pkg::OP_PROBE_READ;
      S_PROBED: if (!stat.out_busy) begin
        cmd.op = xswe_pkg::OP_PROBE_DONE;
        cmd.last = 1'b1;
      end
      default: cmd.op = xswe_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      fn <= '0;
      k <= '0;
      cnt <= '0;
      lvl <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == xswe_pkg::CLR_W'(xswe_pkg::STACK_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          fn <= func;
          k <= '0;
          lvl <= nest_level[4:0];
          cnt <= nest_level[4:0] - 5'd1;
          unique case (xswe_pkg::func_t'(func))
            xswe_pkg::FN_PUSH_VAL, xswe_pkg::FN_PUSH_REG: state <= S_PUSH;
            xswe_pkg::FN_POP_REG, xswe_pkg::FN_POP_OUT, xswe_pkg::FN_LEAVE: state <= S_POPR;
            xswe_pkg::FN_PUSHA: state <= S_PUSHA;
            xswe_pkg::FN_POPA: state <= S_POPAR;
            default: state <= S_EBP;
          endcase
        end
        S_PUSH: if (!stat.out_busy) state <= S_IDLE;
        S_POPR: state <= S_POPD;
        S_POPD: if (!stat.out_busy) state <= S_IDLE;
        S_PUSHA: if (!stat.out_busy) begin
          k <= k + 3'd1;
          if (k == 3'd7) state <= S_IDLE;
        end
        S_POPAR: state <= S_POPAD;
        S_POPAD: if (!stat.out_busy) begin
          k <= k + 3'd1;
          state <= (k == 3'd7) ? S_IDLE : S_POPAR;
        end
        S_EBP: if (!stat.out_busy) begin
          if (lvl == 5'd0) state <= S_ESUB;
          else if (cnt == 5'd0) state <= S_EFRAME;
          else state <= S_DISP_R;
        end
        S_DISP_R: state <= S_DISP_W;
        S_DISP_W: if (!stat.out_busy) begin
          cnt <= cnt - 5'd1;
          state <= (cnt == 5'd1) ? S_EFRAME : S_DISP_R;
        end
        S_EFRAME: if (!stat.out_busy) state <= S_ESUB;
        S_ESUB: state <= S_PROBER;
        S_PROBER: state <= S_PROBED;
        S_PROBED: if (!stat.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/xswe_dp.sv
// Datapath: register file, stack store and output register.
`default_nettype none
module xswe_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            stack_big,
  input  wire xswe_pkg::cmd_t  cmd,
  output xswe_pkg::stat_t      stat,
  input  wire logic [2:0]      func,
  input  wire logic [2:0]      reg_index,
  input  wire logic [15:0]     push_value,
  input  wire logic [15:0]     frame_bytes,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          mem_address,
  output logic [15:0]          mem_data,
  output logic                 mem_write,
  output logic                 last
);
  logic [31:0] regs [8];
  logic [15:0] mem [xswe_pkg::STACK_WORDS];
  logic [15:0] rd_data;
  logic [2:0]  fn;
  logic [2:0]  ri;
  logic [15:0] pv;
  logic [15:0] fb;
  logic [15:0] sp0;    // SP snapshot for PUSHA
  logic [15:0] frame;
  logic [31:0] bp_tmp;
  logic [31:0] rd_addr;
  logic [31:0] rd_addr_q;

  logic [31:0] sp_cur, sp_dec, bp_dec, wdata_addr, sp_sub, sp_inc;
  logic [15:0] src_word;
  logic [31:0] pop_base;
  logic        do_write;
  logic        do_read;
  logic        emit;
  logic [xswe_pkg::STACK_WORDS_LOG2-1:0] w_idx, r_idx;

  function automatic logic [31:0] wrap(input logic big, input logic [31:0] a);
    wrap = big ? a : {16'h0, a[15:0]};
  endfunction

  assign stat.out_busy = out_valid && !out_ready;

  always_comb begin
    sp_cur = wrap(stack_big, regs[xswe_pkg::R_SP]);
    sp_dec = wrap(stack_big, sp_cur - 32'd2);
    bp_dec = wrap(stack_big, bp_tmp - 32'd2);
    sp_sub = wrap(stack_big, sp_cur - {16'h0, fb});
    sp_inc = rd_addr_q + 32'd2;
    pop_base = (fn == xswe_pkg::FN_LEAVE) ? wrap(stack_big, regs[xswe_pkg::R_BP]) : sp_cur;
    unique case (cmd.src)
      xswe_pkg::SRC_VALUE: src_word = pv;
      xswe_pkg::SRC_REG:   src_word = regs[ri][15:0];
      xswe_pkg::SRC_BP:    src_word = regs[xswe_pkg::R_BP][15:0];
      xswe_pkg::SRC_DISP:  src_word = rd_data;
      xswe_pkg::SRC_FRAME: src_word = frame;
      xswe_pkg::SRC_PUSHA: src_word = (cmd.k == xswe_pkg::R_SP) ? sp0 : regs[cmd.k][15:0];
      default:             src_word = pv;
    endcase
    do_write = (cmd.op == xswe_pkg::OP_CLEAR) || (cmd.op == xswe_pkg::OP_PUSH);
    do_read = (cmd.op == xswe_pkg::OP_POP_READ) || (cmd.op == xswe_pkg::OP_DISP_READ) ||
              (cmd.op == xswe_pkg::OP_PROBE_READ);
    emit = (cmd.op == xswe_pkg::OP_PUSH) || (cmd.op == xswe_pkg::OP_POP_DONE) ||
           (cmd.op == xswe_pkg::OP_PROBE_DONE);
    w_idx = (cmd.op == xswe_pkg::OP_CLEAR) ?
            cmd.clr_idx[xswe_pkg::STACK_WORDS_LOG2-1:0] :
            sp_dec[xswe_pkg::STACK_WORDS_LOG2:1];
    wdata_addr = sp_dec;
    if (cmd.op == xswe_pkg::OP_DISP_READ) rd_addr = bp_dec;
    else if (cmd.op == xswe_pkg::OP_PROBE_READ) rd_addr = sp_cur;
    else rd_addr = pop_base;
    r_idx = rd_addr[xswe_pkg::STACK_WORDS_LOG2:1];
  end

  // Stack store: one write and one registered read per cycle. The read data
  // holds until the next read so that a stalled access keeps its word.
  always_ff @(posedge clk) begin
    if (do_write) mem[w_idx] <= (cmd.op == xswe_pkg::OP_CLEAR) ? 16'h0 : src_word;
    if (do_read) rd_data <= mem[r_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
    end else begin
      if (out_valid && out_ready && !emit) out_valid <= 1'b0;
      unique case (cmd.op)
        xswe_pkg::OP_LATCH: begin
          fn <= func;
          ri <= reg_index;
          pv <= push_value;
          fb <= frame_bytes;
          sp0 <= sp_cur[15:0];
          bp_tmp <= wrap(stack_big, regs[xswe_pkg::R_BP]);
        end
        xswe_pkg::OP_PUSH: begin
          if (stack_big) regs[xswe_pkg::R_SP] <= sp_dec;
          else regs[xswe_pkg::R_SP][15:0] <= sp_dec[15:0];
          if (cmd.src == xswe_pkg::SRC_BP) frame <= sp_dec[15:0];
          out_valid <= 1'b1;
          mem_address <= wdata_addr;
          mem_data <= src_word;
          mem_write <= 1'b1;
          last <= cmd.last;
        end
        xswe_pkg::OP_POP_READ: rd_addr_q <= rd_addr;
        xswe_pkg::OP_DISP_READ: bp_tmp <= bp_dec;
        xswe_pkg::OP_PROBE_READ: rd_addr_q <= rd_addr;
        xswe_pkg::OP_POP_DONE: begin
          out_valid <= 1'b1;
          mem_address <= rd_addr_q;
          mem_data <= rd_data;
          mem_write <= 1'b0;
          last <= cmd.last;
          // A pop into SP replaces the low word after the increment.
          if ((fn == xswe_pkg::FN_POP_REG) && (ri == xswe_pkg::R_SP)) begin
            if (stack_big) regs[xswe_pkg::R_SP] <= {sp_inc[31:16], rd_data};
            else regs[xswe_pkg::R_SP][15:0] <= rd_data;
          end else begin
            if (stack_big) regs[xswe_pkg::R_SP] <= sp_inc;
            else regs[xswe_pkg::R_SP][15:0] <= sp_inc[15:0];
          end
          if (fn == xswe_pkg::FN_POP_REG) begin
            if (ri != xswe_pkg::R_SP) regs[ri][15:0] <= rd_data;
          end else if (fn == xswe_pkg::FN_LEAVE) begin
            regs[xswe_pkg::R_BP][15:0] <= rd_data;
          end else if (fn == xswe_pkg::FN_POPA) begin
            if ((3'd7 - cmd.k) != xswe_pkg::R_SP) regs[3'd7 - cmd.k][15:0] <= rd_data;
          end
        end
        xswe_pkg::OP_FRAME: begin
          if (stack_big) regs[xswe_pkg::R_SP] <= sp_sub;
          else regs[xswe_pkg::R_SP][15:0] <= sp_sub[15:0];
        end
        xswe_pkg::OP_PROBE_DONE: begin
          out_valid <= 1'b1;
          mem_address <= rd_addr_q;
          mem_data <= rd_data;
          mem_write <= 1'b0;
          last <= 1'b1;
          regs[xswe_pkg::R_BP][15:0] <= frame;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: dv/x86_stack_word_engine_test.sv
// Self-checking testbench for the x86 16-bit stack instruction engine.
`default_nettype none
module x86_stack_word_engine_test;

  // One stack access as it appears on the output channel.
  typedef struct {
    logic [31:0] addr;
    logic [15:0] data;
    logic        wr;
    logic        fin;
  } access_t;

  // A row of the directed table. When has_exp is set, exp is the one access
  // the row must cause and is compared in place of the predictor's answer.
  typedef struct {
    logic [2:0]  fn;
    logic [2:0]  ri;
    logic [15:0] pv;
    logic [15:0] fb;
    logic [7:0]  lvl;
    logic        has_exp;
    access_t     exp;
  } row_t;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic stack_big = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] func = '0;
  logic [2:0] reg_index = '0;
  logic [15:0] push_value = '0;
  logic [15:0] frame_bytes = '0;
  logic [7:0] nest_level = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] mem_address;
  logic [15:0] mem_data;
  logic mem_write;
  logic last;

  x86_stack_word_engine u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .stack_big(stack_big),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .reg_index(reg_index), .push_value(push_value),
    .frame_bytes(frame_bytes), .nest_level(nest_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .mem_address(mem_address), .mem_data(mem_data),
    .mem_write(mem_write), .last(last)
  );

  always #4 clk = ~clk;

  // The predictor's own copy of the engine state.
  logic [31:0] regs [8];
  logic [15:0] words [xswe_pkg::STACK_WORDS];
  logic        big_mode;

  access_t pending_accesses[$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off = 0;

  // Receiver hold-off, counted in this process; the sender keeps offering.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output checker: every transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_accesses.size() == 0) begin
        report_mismatch("unexpected access", 0, mem_address);
      end else begin
        access_t e;
        e = pending_accesses.pop_front();
        if (mem_address !== e.addr) report_mismatch("mem_address", e.addr, mem_address);
        if (mem_data !== e.data) report_mismatch("mem_data", e.data, mem_data);
        if (mem_write !== e.wr) report_mismatch("mem_write", e.wr, mem_write);
        if (last !== e.fin) report_mismatch("last", e.fin, last);
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("timeout with %0d accesses outstanding", pending_accesses.size());
      $display("x86_stack_word_engine_test NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  function automatic logic [31:0] wrap_addr(input logic [31:0] a);
    return big_mode ? a : {16'h0, a[15:0]};
  endfunction

  function automatic logic [31:0] cur_sp();
    return wrap_addr(regs[xswe_pkg::R_SP]);
  endfunction

  // In 16-bit mode only the low half of SP/BP changes.
  function automatic void set_ptr(input logic [2:0] r, input logic [31:0] v);
    if (big_mode) regs[r] = v;
    else regs[r][15:0] = v[15:0];
  endfunction

  function automatic xswe_pkg::word_idx_t slot(input logic [31:0] a);
    return a[xswe_pkg::STACK_WORDS_LOG2:1];
  endfunction

  function automatic void note_access(input logic [31:0] a, input logic [15:0] d,
                                      input logic wr);
    access_t x;
    x.addr = a;
    x.data = d;
    x.wr = wr;
    x.fin = 1'b0;
    pending_accesses.push_back(x);
  endfunction

  function automatic void store_word(input logic [31:0] a, input logic [15:0] v);
    logic [31:0] w;
    w = wrap_addr(a);
    words[slot(w)] = v;
    note_access(w, v, 1'b1);
  endfunction

  function automatic logic [15:0] load_word(input logic [31:0] a);
    logic [31:0] w;
    w = wrap_addr(a);
    note_access(w, words[slot(w)], 1'b0);
    return words[slot(w)];
  endfunction

  function automatic void push_word(input logic [15:0] v);
    logic [31:0] sp;
    sp = wrap_addr(cur_sp() - 32'd2);
    set_ptr(xswe_pkg::R_SP, sp);
    store_word(sp, v);
  endfunction

  function automatic logic [15:0] pop_word();
    logic [31:0] sp;
    logic [15:0] v;
    sp = cur_sp();
    v = load_word(sp);
    set_ptr(xswe_pkg::R_SP, sp + 32'd2);
    return v;
  endfunction

  // Predicts the accesses of one instruction and appends them to the queue.
  function automatic void predict_instruction(input logic [2:0] fn, input logic [2:0] ri,
                                              input logic [15:0] pv, input logic [15:0] fb,
                                              input logic [7:0] lvl_in);
    logic [31:0] sp0, bp;
    logic [15:0] vals [8];
    logic [15:0] frame, v;
    logic [4:0]  lvl, cnt;
    int first;
    first = pending_accesses.size();
    lvl = lvl_in[4:0];
    case (xswe_pkg::func_t'(fn))
      xswe_pkg::FN_PUSH_VAL: push_word(pv);
      xswe_pkg::FN_PUSH_REG: push_word(regs[ri][15:0]);
      xswe_pkg::FN_POP_REG: begin
        v = pop_word();
        regs[ri][15:0] = v;
      end
      xswe_pkg::FN_POP_OUT: v = pop_word();
      xswe_pkg::FN_PUSHA: begin
        sp0 = cur_sp();
        for (int k = 0; k < 8; k++) vals[k] = regs[k][15:0];
        vals[xswe_pkg::R_SP] = sp0[15:0];
        for (int k = 0; k < 8; k++) store_word(sp0 - 32'(2 * (k + 1)), vals[k]);
        set_ptr(xswe_pkg::R_SP, sp0 - 32'd16);
      end
      xswe_pkg::FN_POPA: begin
        sp0 = cur_sp();
        for (int k = 0; k < 8; k++) vals[7 - k] = load_word(sp0 + 32'(2 * k));
        set_ptr(xswe_pkg::R_SP, sp0 + 32'd16);
        for (int k = 0; k < 8; k++)
          if (k != xswe_pkg::R_SP) regs[k][15:0] = vals[k];
      end
      xswe_pkg::FN_ENTER: begin
        bp = wrap_addr(regs[xswe_pkg::R_BP]);
        push_word(regs[xswe_pkg::R_BP][15:0]);
        sp0 = cur_sp();
        frame = sp0[15:0];
        if (lvl != 0) begin
          // Copy the display: level-1 words from just below the old frame.
          cnt = lvl - 5'd1;
          while (cnt != 0) begin
            bp = wrap_addr(bp - 32'd2);
            push_word(words[slot(bp)]);
            cnt = cnt - 5'd1;
          end
          push_word(frame);
        end
        set_ptr(xswe_pkg::R_SP, cur_sp() - {16'h0, fb});
        v = load_word(cur_sp());
        regs[xswe_pkg::R_BP][15:0] = frame;
      end
      default: begin
        bp = wrap_addr(regs[xswe_pkg::R_BP]);
        v = load_word(bp);
        set_ptr(xswe_pkg::R_SP, bp + 32'd2);
        regs[xswe_pkg::R_BP][15:0] = v;
      end
    endcase
    if (pending_accesses.size() > first)
      pending_accesses[pending_accesses.size() - 1].fin = 1'b1;
  endfunction

  // Offers one instruction and holds it until the transfer; the expected
  // accesses are queued at the same edge the engine takes the item. The
  // task returns at a falling edge, where the caller either offers the next
  // item or drops valid.
  task automatic send_instruction(input logic [2:0] fn, input logic [2:0] ri,
                                  input logic [15:0] pv, input logic [15:0] fb,
                                  input logic [7:0] lvl, input logic has_exp,
                                  input access_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    func <= fn;
    reg_index <= ri;
    push_value <= pv;
    frame_bytes <= fb;
    nest_level <= lvl;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (has_exp) begin
      predict_instruction(fn, ri, pv, fb, lvl);
      void'(pending_accesses.pop_back());
      pending_accesses.push_back(exp);
    end else begin
      predict_instruction(fn, ri, pv, fb, lvl);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_accesses.size() != 0) @(negedge clk);
    // Every instruction leaves an access, so the last one marks the end.
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    drain();
    stack_big <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    big_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random instruction mix: all eight functions equally likely, ENTER mostly shallow.
  task automatic send_random();
    logic [2:0] fn;
    logic [7:0] lvl;
    logic [15:0] fb;
    access_t none;
    none = '{default: '0};
    fn = 3'($urandom_range(7));
    lvl = 8'($urandom_range(255));
    if ($urandom_range(9) < 8) lvl[4:0] = 5'($urandom_range(4));
    fb = 16'($urandom_range(65535));
    if ($urandom_range(3) != 0) fb = 16'($urandom_range(64));
    send_instruction(fn, 3'($urandom_range(7)), 16'($urandom_range(65535)), fb, lvl,
                     1'b0, none);
  endtask

  row_t dir_rows[$];

  function automatic access_t mk(input logic [31:0] a, input logic [15:0] d,
                                 input logic wr);
    access_t x;
    x.addr = a; x.data = d; x.wr = wr; x.fin = 1'b1;
    return x;
  endfunction

  function automatic void add_row(input logic [2:0] fn, input logic [2:0] ri,
                                  input logic [15:0] pv, input logic [15:0] fb,
                                  input logic [7:0] lvl, input logic he,
                                  input access_t e);
    row_t r;
    r.fn = fn; r.ri = ri; r.pv = pv; r.fb = fb; r.lvl = lvl; r.has_exp = he; r.exp = e;
    dir_rows.push_back(r);
  endfunction

  initial begin
    access_t none;
    none = '{default: '0};
    for (int k = 0; k < 8; k++) regs[k] = '0;
    for (int k = 0; k < xswe_pkg::STACK_WORDS; k++) words[k] = '0;
    big_mode = 1'b0;

    // After reset SP is zero, so the first push wraps to FFFE, and the pop
    // that follows reads it back. The rest of the table is predicted.
    add_row(xswe_pkg::FN_PUSH_VAL, 3'd0, 16'hFFFF, 16'h0, 8'd0, 1'b1,
            mk(32'h0000FFFE, 16'hFFFF, 1'b1));
    add_row(xswe_pkg::FN_POP_OUT, 3'd0, 16'h0, 16'h0, 8'd0, 1'b1,
            mk(32'h0000FFFE, 16'hFFFF, 1'b0));
    add_row(xswe_pkg::FN_PUSH_VAL, 3'd0, 16'h0000, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_PUSH_REG, xswe_pkg::R_SP, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_POP_REG, 3'd0, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_POP_REG, xswe_pkg::R_SP, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_PUSHA, 3'd0, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_POPA, 3'd0, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_ENTER, 3'd0, 16'h0, 16'h0000, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_ENTER, 3'd0, 16'h0, 16'h0010, 8'd1, 1'b0, none);
    add_row(xswe_pkg::FN_ENTER, 3'd0, 16'h0, 16'hFFFF, 8'd3, 1'b0, none);
    add_row(xswe_pkg::FN_LEAVE, 3'd0, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_ENTER, 3'd0, 16'h0, 16'h0004, 8'hFF, 1'b0, none);
    add_row(xswe_pkg::FN_ENTER, 3'd0, 16'h0, 16'h0002, 8'h20, 1'b0, none);
    add_row(xswe_pkg::FN_LEAVE, 3'd0, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_POP_REG, 3'd7, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_PUSH_REG, 3'd7, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_POP_REG, xswe_pkg::R_BP, 16'h0, 16'h0, 8'd0, 1'b0, none);
    add_row(xswe_pkg::FN_LEAVE, 3'd0, 16'h0, 16'h0, 8'd0, 1'b0, none);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    foreach (dir_rows[i])
      send_instruction(dir_rows[i].fn, dir_rows[i].ri, dir_rows[i].pv, dir_rows[i].fb,
                       dir_rows[i].lvl, dir_rows[i].has_exp, dir_rows[i].exp);
    // Same rows in big-stack mode, where SP leaves the 16-bit window.
    write_mode(1'b1);
    foreach (dir_rows[i])
      send_instruction(dir_rows[i].fn, dir_rows[i].ri, dir_rows[i].pv, dir_rows[i].fb,
                       dir_rows[i].lvl, 1'b0, none);

    // Random phases: idling pattern and stack mode change between phases.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      write_mode(ph[0] ^ ph[2]);
      if (ph == 4) hold_off = 600;
      for (int n = 0; n < 42; n++) send_random();
      // In phase 1 the sender waits here until every access of the phase has come.
      if (ph == 1) drain();
    end

    drain();
    if (errors == 0)
      $display("x86_stack_word_engine_test OK");
    else
      $display("x86_stack_word_engine_test NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
